>>> rtl/cca_pkg.sv
package cca_pkg;

  localparam int CCA_NUM_CLUSTERS = 4096;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_EXTEND = 3'd2;
  localparam logic [2:0] CMD_DROP   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOFREE = 3'd1;
  localparam logic [2:0] ST_SHORT  = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_LIMIT  = 3'd4;

  typedef logic [4:0] pc_t;

  localparam pc_t P_IDLE      = 5'd0;
  localparam pc_t P_A0        = 5'd1;
  localparam pc_t P_A1        = 5'd2;
  localparam pc_t P_F0        = 5'd3;
  localparam pc_t P_F1        = 5'd4;
  localparam pc_t P_F2        = 5'd5;
  localparam pc_t P_E0        = 5'd6;
  localparam pc_t P_E1        = 5'd7;
  localparam pc_t P_E2        = 5'd8;
  localparam pc_t P_EM_LIMIT  = 5'd9;
  localparam pc_t P_X0        = 5'd10;
  localparam pc_t P_X1        = 5'd11;
  localparam pc_t P_X2        = 5'd12;
  localparam pc_t P_D0        = 5'd13;
  localparam pc_t P_D1        = 5'd14;
  localparam pc_t P_D2        = 5'd15;
  localparam pc_t P_D3        = 5'd16;
  localparam pc_t P_D4        = 5'd17;
  localparam pc_t P_D5        = 5'd18;
  localparam pc_t P_D6        = 5'd19;
  localparam pc_t P_R0        = 5'd20;
  localparam pc_t P_R1        = 5'd21;
  localparam pc_t P_EM_C      = 5'd22;
  localparam pc_t P_EM_OK0    = 5'd23;
  localparam pc_t P_EM_NOFREE = 5'd24;
  localparam pc_t P_EM_SHORT  = 5'd25;
  localparam pc_t P_EM_ZERO   = 5'd26;

  typedef enum logic [2:0] {
    CND_NEXT, CND_ALWAYS, CND_DISPATCH, CND_FH_ZERO,
    CND_CID_ZERO, CND_RD_ZERO, CND_LIMIT, CND_NOT_LIMIT
  } cond_t;

  typedef enum logic [1:0] {RS_NONE, RS_CID, RS_FH, RS_RD} rsel_t;

  typedef enum logic [2:0] {
    WS_NONE, WS_FH_ZERO, WS_CID_FH, WS_CID_C, WS_CID_ZERO, WS_C_FH
  } wsel_t;

  typedef enum logic [1:0] {LC_KEEP, LC_FH, LC_RD} ldc_t;
  typedef enum logic [1:0] {LF_KEEP, LF_RD, LF_CID, LF_C} ldfh_t;
  typedef enum logic [1:0] {LI_KEEP, LI_RD, LI_C} ldcid_t;
  typedef enum logic [1:0] {CS_ZERO, CS_C, CS_RD} clsel_t;

  typedef struct packed {
    cond_t      cond;
    pc_t        target;
    rsel_t      rsel;
    wsel_t      wsel;
    ldc_t       ld_c;
    ldfh_t      ld_fh;
    ldcid_t     ld_cid;
    logic       inc_steps;
    logic       emit;
    logic [2:0] status;
    clsel_t     clsel;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic out_busy;
    logic fh_zero;
    logic cid_zero;
    logic rd_zero;
    logic limit;
  } seq_flags_t;

  localparam ucode_t UC_NOP = '{
    cond: CND_NEXT, target: P_IDLE, rsel: RS_NONE, wsel: WS_NONE,
    ld_c: LC_KEEP, ld_fh: LF_KEEP, ld_cid: LI_KEEP, inc_steps: 1'b0,
    emit: 1'b0, status: ST_OK, clsel: CS_ZERO
  };

  function automatic ucode_t emit_word(input logic [2:0] st, input clsel_t cs);
    ucode_t w;
    w        = UC_NOP;
    w.cond   = CND_ALWAYS;
    w.target = P_IDLE;
    w.emit   = 1'b1;
    w.status = st;
    w.clsel  = cs;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      P_IDLE: begin
        w.cond = CND_DISPATCH;
      end
      P_A0, P_X0: begin
        w.cond   = CND_FH_ZERO;
        w.target = P_EM_NOFREE;
        w.rsel   = RS_FH;
      end
      P_A1: begin
        w.ld_c   = LC_FH;
        w.ld_fh  = LF_RD;
        w.wsel   = WS_FH_ZERO;
        w.cond   = CND_ALWAYS;
        w.target = P_EM_C;
      end
      P_F0: begin
        w.cond   = CND_CID_ZERO;
        w.target = P_EM_OK0;
      end
      P_F1: begin
        w.cond   = CND_LIMIT;
        w.target = P_EM_LIMIT;
        w.rsel   = RS_CID;
      end
      P_F2: begin
        w.wsel      = WS_CID_FH;
        w.ld_fh     = LF_CID;
        w.ld_cid    = LI_RD;
        w.inc_steps = 1'b1;
        w.cond      = CND_ALWAYS;
        w.target    = P_F0;
      end
      P_E0, P_D0, P_R0: begin
        w.rsel = RS_CID;
      end
      P_E1: begin
        w.cond   = CND_RD_ZERO;
        w.target = P_X0;
      end
      P_E2: begin
        w.cond      = CND_NOT_LIMIT;
        w.target    = P_E1;
        w.ld_cid    = LI_RD;
        w.inc_steps = 1'b1;
        w.rsel      = RS_RD;
      end
      P_EM_LIMIT, P_D4: begin
        w = emit_word(ST_LIMIT, CS_ZERO);
      end
      P_X1: begin
        w.ld_c  = LC_FH;
        w.ld_fh = LF_RD;
        w.wsel  = WS_FH_ZERO;
      end
      P_X2: begin
        w.wsel   = WS_CID_C;
        w.cond   = CND_ALWAYS;
        w.target = P_EM_C;
      end
      P_D1: begin
        w.cond   = CND_RD_ZERO;
        w.target = P_EM_SHORT;
        w.ld_c   = LC_RD;
        w.rsel   = RS_RD;
      end
      P_D2: begin
        w.cond   = CND_RD_ZERO;
        w.target = P_D5;
      end
      P_D3: begin
        w.cond      = CND_NOT_LIMIT;
        w.target    = P_D2;
        w.ld_cid    = LI_C;
        w.ld_c      = LC_RD;
        w.inc_steps = 1'b1;
        w.rsel      = RS_RD;
      end
      P_D5: begin
        w.wsel = WS_CID_ZERO;
      end
      P_D6: begin
        w.wsel   = WS_C_FH;
        w.ld_fh  = LF_C;
        w.cond   = CND_ALWAYS;
        w.target = P_EM_C;
      end
      P_R1:        w = emit_word(ST_OK, CS_RD);
      P_EM_C:      w = emit_word(ST_OK, CS_C);
      P_EM_OK0:    w = emit_word(ST_OK, CS_ZERO);
      P_EM_NOFREE: w = emit_word(ST_NOFREE, CS_ZERO);
      P_EM_SHORT:  w = emit_word(ST_SHORT, CS_ZERO);
      P_EM_ZERO:   w = emit_word(ST_ZERO, CS_ZERO);
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = P_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(input logic [2:0] cmd, input logic start_zero,
                                   input logic start_big);
    pc_t p;
    p = P_EM_OK0;
    unique case (cmd)
      CMD_ALLOC:  p = P_A0;
      CMD_FREE:   p = P_F0;
      CMD_EXTEND: p = P_E0;
      CMD_DROP:   p = P_D0;
      CMD_READ:   p = P_R0;
      default:    p = P_EM_OK0;
    endcase
    if (cmd inside {CMD_FREE, CMD_EXTEND, CMD_DROP, CMD_READ}) begin
      if (start_zero) begin
        p = P_EM_ZERO;
      end else if (start_big) begin
        p = P_EM_LIMIT;
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/cca_useq.sv
module cca_useq
  import cca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  seq_flags_t flags,
  input  pc_t        entry,
  output ucode_t     uc,
  output logic       idle
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic take;

  assign uc   = ucode_rom(pc_r);
  assign idle = (pc_r == P_IDLE);

  always_comb begin
    case (uc.cond)
      CND_ALWAYS:    take = 1'b1;
      CND_FH_ZERO:   take = flags.fh_zero;
      CND_CID_ZERO:  take = flags.cid_zero;
      CND_RD_ZERO:   take = flags.rd_zero;
      CND_LIMIT:     take = flags.limit;
      CND_NOT_LIMIT: take = !flags.limit;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (uc.cond == CND_DISPATCH) begin
      pc_nxt = flags.accept ? entry : pc_r;
    end else if (uc.emit && flags.out_busy) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = uc.target;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/cluster_chain_allocator_top.sv
// Channel  Direction  Signals                         Fields, lowest bit first
// in       slave      in_tvalid, in_tready, in_tdata  cmd[2:0], start_cluster[14:3]
// out      master     out_tvalid, out_tready, out_tdata  cluster[11:0], status[14:12]
//
// Every command returns one word. Free chain, extend and drop take longer the more links
// they walk; the link memory with its registered read sets the pace of each step.
// After reset the link memory is initialized, with in_tready low.
// A held output word stalls the sequencer only at the step that writes the next result.
module cluster_chain_allocator_top
  import cca_pkg::*;
#(
  parameter int NUM_CLUSTERS = CCA_NUM_CLUSTERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd, start_cluster
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // cluster, status
);

  localparam int CW = $clog2(NUM_CLUSTERS);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] LIMIT_STEPS = SW'(NUM_CLUSTERS);
  localparam logic [CW-1:0] LAST_IDX    = CW'(NUM_CLUSTERS - 1);

  logic [CW-1:0] mem [NUM_CLUSTERS];

  logic [CW-1:0] cid_r, c_r, fh_r, rd_r, clr_idx_r, clr_val;
  logic [SW-1:0] steps_r;
  logic          clr_busy_r;
  logic          out_valid_r;
  logic [15:0]   out_tdata_r;

  logic [2:0]    in_cmd;
  logic [11:0]   in_start;
  logic          accept, idle, out_busy, start_big;
  logic          we, re;
  logic [CW-1:0] waddr, wdata, raddr;
  logic [11:0]   cl_out;
  ucode_t        uc;
  seq_flags_t    flags;
  pc_t           entry;

  assign in_cmd    = in_tdata[2:0];
  assign in_start  = in_tdata[14:3];
  assign in_tready = idle && !clr_busy_r;
  assign accept    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign start_big = (32'(in_start) >= NUM_CLUSTERS);
  assign entry     = entry_pc(in_cmd, in_start == 12'd0, start_big);

  assign flags.accept   = accept;
  assign flags.out_busy = out_busy;
  assign flags.fh_zero  = (fh_r == '0);
  assign flags.cid_zero = (cid_r == '0);
  assign flags.rd_zero  = (rd_r == '0);
  assign flags.limit    = (steps_r >= LIMIT_STEPS);

  cca_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .entry (entry),
    .uc    (uc),
    .idle  (idle)
  );

  assign clr_val = (clr_idx_r != '0 && clr_idx_r != LAST_IDX) ? clr_idx_r + 1'b1 : '0;

  always_comb begin
    we    = 1'b0;
    waddr = cid_r;
    wdata = '0;
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = clr_val;
    end else begin
      unique case (uc.wsel)
        WS_FH_ZERO: begin
          we    = 1'b1;
          waddr = fh_r;
        end
        WS_CID_FH: begin
          we    = 1'b1;
          wdata = fh_r;
        end
        WS_CID_C: begin
          we    = 1'b1;
          wdata = c_r;
        end
        WS_CID_ZERO: begin
          we = 1'b1;
        end
        WS_C_FH: begin
          we    = 1'b1;
          waddr = c_r;
          wdata = fh_r;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_comb begin
    re = (uc.rsel != RS_NONE);
    unique case (uc.rsel)
      RS_FH:   raddr = fh_r;
      RS_RD:   raddr = rd_r;
      default: raddr = cid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r    <= CW'(1);
      steps_r <= '0;
    end else begin
      case (uc.ld_fh)
        LF_RD:   fh_r <= rd_r;
        LF_CID:  fh_r <= cid_r;
        LF_C:    fh_r <= c_r;
        default: fh_r <= fh_r;
      endcase
      if (accept) begin
        steps_r <= '0;
      end else if (uc.inc_steps && !flags.limit) begin
        steps_r <= steps_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cid_r <= CW'(in_start);
    end else begin
      case (uc.ld_cid)
        LI_RD:   cid_r <= rd_r;
        LI_C:    cid_r <= c_r;
        default: cid_r <= cid_r;
      endcase
    end
    case (uc.ld_c)
      LC_FH:   c_r <= fh_r;
      LC_RD:   c_r <= rd_r;
      default: c_r <= c_r;
    endcase
  end

  always_comb begin
    case (uc.clsel)
      CS_C:    cl_out = 12'(c_r);
      CS_RD:   cl_out = 12'(rd_r);
      default: cl_out = 12'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uc.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.emit && !out_busy) begin
      out_tdata_r <= {1'b0, uc.status, cl_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_no_rw_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("link memory read and write collide on one address");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= LIMIT_STEPS)
    else $error("walk step count ran past the cluster count");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("sequencer stayed idle after taking a command");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tdata_r[14:12] <= ST_LIMIT))
    else $error("result word carries an undefined status");

  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (idle && !uc.emit))
    else $error("sequencer active during link memory initialization");

endmodule

>>> sim/tb_cluster_chain_allocator_top.sv
module tb_cluster_chain_allocator_top;
  import cca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 3_000_000;
  localparam int LONG_WALK = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] cluster;
  } chain_result_t;

  class alloc_scoreboard;
    logic [11:0]   link_tbl [CCA_NUM_CLUSTERS];
    logic [11:0]   free_head;
    chain_result_t expected_words [$];
    int            errors;

    function new();
      for (int i = 0; i < CCA_NUM_CLUSTERS; i++) begin
        link_tbl[i] = (i >= 1 && i + 1 < CCA_NUM_CLUSTERS) ? 12'(i + 1) : 12'd0;
      end
      free_head = 12'd1;
      errors = 0;
    endfunction

    // Number of clusters reached from start before a zero link, capped past the table size.
    function int chain_len(logic [11:0] start);
      logic [11:0] cid;
      int n;
      cid = start;
      n = 0;
      while (cid != 0 && n <= CCA_NUM_CLUSTERS) begin
        cid = link_tbl[cid];
        n++;
      end
      return n;
    endfunction

    function void note_input(logic [2:0] cmd, logic [11:0] start);
      chain_result_t res;
      logic [11:0] cid, nxt, c;
      int steps;
      res.cluster = '0;
      res.status = ST_OK;
      steps = 0;
      cid = start;
      if (cmd == CMD_ALLOC) begin
        if (free_head == 0) begin
          res.status = ST_NOFREE;
        end else begin
          c = free_head;
          free_head = link_tbl[c];
          link_tbl[c] = '0;
          res.cluster = c;
        end
      end else if (cmd > CMD_READ) begin
        res.status = ST_OK;
      end else if (start == 0) begin
        res.status = ST_ZERO;
      end else if (int'(start) >= CCA_NUM_CLUSTERS) begin
        res.status = ST_LIMIT;
      end else begin
        case (cmd)
          CMD_READ: begin
            res.cluster = link_tbl[start];
          end
          CMD_FREE: begin
            while (cid != 0 && res.status == ST_OK) begin
              if (steps >= CCA_NUM_CLUSTERS) begin
                res.status = ST_LIMIT;
              end else begin
                nxt = link_tbl[cid];
                link_tbl[cid] = free_head;
                free_head = cid;
                cid = nxt;
                steps++;
              end
            end
          end
          CMD_EXTEND: begin
            while (link_tbl[cid] != 0 && res.status == ST_OK) begin
              if (steps >= CCA_NUM_CLUSTERS) begin
                res.status = ST_LIMIT;
              end else begin
                cid = link_tbl[cid];
                steps++;
              end
            end
            if (res.status == ST_OK) begin
              if (free_head == 0) begin
                res.status = ST_NOFREE;
              end else begin
                c = free_head;
                free_head = link_tbl[c];
                link_tbl[c] = '0;
                link_tbl[cid] = c;
                res.cluster = c;
              end
            end
          end
          default: begin
            if (link_tbl[start] == 0) begin
              res.status = ST_SHORT;
            end else begin
              while (link_tbl[link_tbl[cid]] != 0 && res.status == ST_OK) begin
                if (steps >= CCA_NUM_CLUSTERS) begin
                  res.status = ST_LIMIT;
                end else begin
                  cid = link_tbl[cid];
                  steps++;
                end
              end
              if (res.status == ST_OK) begin
                c = link_tbl[cid];
                link_tbl[cid] = '0;
                link_tbl[c] = free_head;
                free_head = c;
                res.cluster = c;
              end
            end
          end
        endcase
      end
      expected_words.push_back(res);
    endfunction

    function void check_result(logic [15:0] word);
      chain_result_t got, want;
      got = word[14:0];
      if (expected_words.size() == 0) begin
        $error("unexpected output word: cluster %0d status %0d", got.cluster, got.status);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got.cluster !== want.cluster) begin
          $error("cluster: expected %0d, actual %0d", want.cluster, got.cluster);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  bit              calm = 1'b0;
  int              cycle_count = 0;
  alloc_scoreboard sb = new();

  cluster_chain_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  task automatic send_word(input logic [2:0] cmd, input logic [11:0] start);
    if (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 21);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, start, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, start);
    @(negedge clk);
  endtask

  task automatic wait_results;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_words.size() != 0);
  endtask

  task automatic run_directed;
    send_word(CMD_ALLOC, 12'hfff);
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_EXTEND, 12'd1);
    send_word(CMD_EXTEND, 12'd1);
    send_word(CMD_READ, 12'd1);
    send_word(CMD_READ, 12'hfff);
    send_word(CMD_READ, 12'hffe);
    send_word(CMD_DROP, 12'd1);
    send_word(CMD_DROP, 12'd2);
    send_word(CMD_FREE, 12'd1);
    send_word(CMD_FREE, 12'd0);
    send_word(CMD_EXTEND, 12'd0);
    send_word(CMD_DROP, 12'd0);
    send_word(CMD_READ, 12'd0);
    for (int k = 1; k <= 3; k++) begin
      send_word(CMD_READ + 3'(k), (k == 2) ? 12'd0 : 12'hfff);
    end
    send_word(CMD_ALLOC, 12'h555);
    send_word(CMD_FREE, 12'd2);
    send_word(CMD_READ, 12'haaa);
  endtask

  // Make a self-linked cluster to hit the walk limit, drain the free list through it,
  // then give everything back.
  task automatic run_exhaust;
    logic [11:0] a;
    logic [11:0] rest;
    a = sb.free_head;
    send_word(CMD_ALLOC, 12'($urandom));
    rest = sb.free_head;
    send_word(CMD_FREE, a);
    send_word(CMD_FREE, a);
    send_word(CMD_EXTEND, a);
    send_word(CMD_DROP, a);
    send_word(CMD_READ, a);
    send_word(CMD_FREE, a);
    send_word(CMD_ALLOC, 12'($urandom));
    send_word(CMD_ALLOC, 12'($urandom));
    send_word(CMD_ALLOC, 12'($urandom));
    send_word(CMD_EXTEND, a);
    send_word(CMD_FREE, a);
    send_word(CMD_FREE, rest);
  endtask

  task automatic run_random(input int count);
    logic [11:0] heads [$];
    logic [2:0]  cmd;
    logic [11:0] start;
    int          pick, idx, heavy_left;
    heavy_left = 12;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 3 && n < count / 2);
      pick = $urandom_range(99);
      cmd = CMD_READ;
      start = 12'($urandom);
      if (heads.size() == 0 || (pick < 25 && heads.size() < 48)) begin
        cmd = CMD_ALLOC;
      end else if (pick < 80) begin
        idx = $urandom_range(heads.size() - 1);
        start = heads[idx];
        if (pick < 50) begin
          cmd = (sb.chain_len(start) > 10) ? CMD_DROP : CMD_EXTEND;
        end else if (pick < 65) begin
          cmd = CMD_DROP;
        end else begin
          cmd = CMD_FREE;
          heads.delete(idx);
        end
      end else if (pick < 92) begin
        if (pick < 84) start = heads[$urandom_range(heads.size() - 1)];
      end else begin
        cmd = 3'($urandom);
        if ($urandom_range(3) == 0) start = '0;
      end
      if (cmd inside {CMD_FREE, CMD_EXTEND, CMD_DROP} && sb.chain_len(start) > LONG_WALK) begin
        if (heavy_left > 0) begin
          heavy_left--;
        end else begin
          cmd = CMD_READ;
        end
      end
      if (cmd == CMD_ALLOC && sb.free_head != 0) heads.push_back(sb.free_head);
      send_word(cmd, start);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    wait_results();
    run_exhaust();
    wait_results();
    run_random(1500);
    wait_results();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
